>>> hdl/saf_pkg.sv
// saf_pkg: shared types and constants of the sample averaging filter.
// Used by saf_ctrl, saf_datapath and sample_averaging_filter. No dependencies.
package saf_pkg;

	localparam int SAF_MAX_WINDOW  = 64;
	localparam int SAF_SAMPLE_BITS = 16;
	localparam int TRIM_MIN_WINDOW = 3;

	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		MODE_SLIDING  = 2'd0,
		MODE_TRIMMED  = 2'd1,
		MODE_WEIGHTED = 2'd2,
		MODE_BLOCK    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LOAD,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic div_load;
		logic div_step;
		logic out_load;
	} saf_cmd_t;

	typedef struct packed {
		logic emit;
		logic div_last;
		logic out_busy;
	} saf_status_t;

endpackage

>>> hdl/sample_averaging_filter.sv
// Sample averaging filter: sliding, trimmed, weighted and plain means.
// The result of a beat comes from the one-bit-per-cycle restoring divider, and no new beat
// is accepted before that result is in the output register; beats that give no result
// go back to idle after the update. A finished result waits in the output register.
// arst_n clears config (mode 0, window 1) and all window state; no RAM clearing pass.
module sample_averaging_filter
	import saf_pkg::*;
#(
	parameter int MAX_WINDOW  = SAF_MAX_WINDOW,
	parameter int SAMPLE_BITS = SAF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [CFG_INDEX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_wdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
	input  logic                                  s_tuser,  // first_of_record
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata   // filtered_value
);

	localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

	saf_cmd_t               cmd;
	saf_status_t            status;
	logic [SAMPLE_BITS-1:0] out_value;

	saf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	saf_datapath #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_sample(s_tdata[SAMPLE_BITS-1:0]),
		.in_first (s_tuser),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_value(out_value),
		.cmd      (cmd),
		.status   (status)
	);

	assign m_tdata = TDW'(out_value);

endmodule

>>> hdl/saf_ram.sv
// saf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module saf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/saf_ctrl.sv
// saf_ctrl: sequencer of the sample averaging filter.
// Depends on saf_pkg; drives saf_datapath through saf_cmd_t.
module saf_ctrl
	import saf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  saf_status_t status,
	output saf_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = status.emit ? ST_LOAD : ST_IDLE;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold the quotient until the output register frees up
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/saf_datapath.sv
// saf_datapath: config registers, window/block state, window RAM, restoring
// divider and output register. Depends on saf_pkg and saf_ram.
module saf_datapath
	import saf_pkg::*;
#(
	parameter int MAX_WINDOW  = SAF_MAX_WINDOW,
	parameter int SAMPLE_BITS = SAF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   in_first,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] out_value,
	input  saf_cmd_t               cmd,
	output saf_status_t            status
);

	localparam int S    = SAMPLE_BITS;
	localparam int WW   = $clog2(MAX_WINDOW + 1);
	localparam int AW   = $clog2(MAX_WINDOW);
	localparam int RSW  = S + AW;
	localparam int WSUM = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
	localparam int DVW  = $clog2(WSUM + 1);
	localparam int BSW  = S + DVW;
	localparam int DW   = BSW;
	localparam int CNTW = $clog2(DW);
	localparam int TPW  = 2 * WW + 2;

	// configuration
	mode_t                 mode_q;
	logic [CFG_DATA_W-1:0] wlen_q;
	logic [WW-1:0]         w_eff;

	// captured beat
	logic [S-1:0] sample_q;
	logic         first_q;

	// filter state
	logic [RSW-1:0] sum_q;
	logic [BSW-1:0] bsum_q;
	logic [S-1:0]   min_q, max_q;
	logic [WW-1:0]  fill_q;
	logic [AW-1:0]  ptr_q;

	// divider
	logic [DW-1:0]   quo_q;
	logic [DVW-1:0]  rem_q, dvs_q;
	logic [CNTW-1:0] cnt_q;

	logic [S-1:0] out_q;
	logic         out_valid_q;

	logic [S-1:0] rd_data;

	always_comb begin
		if (wlen_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(wlen_q) > MAX_WINDOW) begin
			w_eff = WW'(MAX_WINDOW);
		end else begin
			w_eff = WW'(wlen_q);
		end
	end

	// ---- sample update ----
	logic [WW-1:0]   fill_eff, fill_slide, fill_base, fill_blk, ptr_inc;
	logic [RSW-1:0]  sum_eff, sum_upd;
	logic [AW-1:0]   ptr_eff, ptr_next;
	logic            slide_full, blk_done, trim_drop;
	logic [BSW-1:0]  bsum_base, bsum_upd;
	logic [S-1:0]    min_upd, max_upd;
	logic [S+WW-1:0] wgt_prod;

	assign wgt_prod = {{WW{1'b0}}, sample_q} * {{S{1'b0}}, fill_blk};

	always_comb begin
		fill_eff   = first_q ? '0 : fill_q;
		sum_eff    = first_q ? '0 : sum_q;
		ptr_eff    = first_q ? '0 : ptr_q;
		slide_full = (fill_eff >= w_eff);

		sum_upd    = (slide_full ? sum_eff - RSW'(rd_data) : sum_eff) + RSW'(sample_q);
		fill_slide = slide_full ? fill_eff : fill_eff + WW'(1);
		ptr_inc    = WW'(ptr_eff) + WW'(1);
		ptr_next   = (ptr_inc == w_eff) ? '0 : AW'(ptr_inc);

		// a new block starts when empty or after a full one
		fill_base = slide_full || (fill_eff == '0) ? '0 : fill_eff;
		fill_blk  = fill_base + WW'(1);
		if (fill_base == '0) begin
			bsum_base = '0;
			min_upd   = sample_q;
			max_upd   = sample_q;
		end else begin
			bsum_base = bsum_q;
			min_upd   = (sample_q < min_q) ? sample_q : min_q;
			max_upd   = (sample_q > max_q) ? sample_q : max_q;
		end
		bsum_upd = bsum_base +
			((mode_q == MODE_WEIGHTED) ? BSW'(wgt_prod) : BSW'(sample_q));

		blk_done  = (fill_blk == w_eff);
		trim_drop = blk_done && (mode_q == MODE_TRIMMED) &&
			(w_eff < WW'(TRIM_MIN_WINDOW));
	end

	assign status.emit = (mode_q == MODE_SLIDING) ? (fill_slide == w_eff)
		: (blk_done && !trim_drop);

	// ---- divider operands ----
	logic [DW-1:0]  dividend;
	logic [DVW-1:0] divisor;
	logic [TPW-1:0] tri_prod;

	assign tri_prod = TPW'(w_eff) * (TPW'(w_eff) + TPW'(1));

	always_comb begin
		case (mode_q)
			MODE_SLIDING: begin
				dividend = DW'(sum_q);
				divisor  = DVW'(w_eff);
			end
			MODE_TRIMMED: begin
				dividend = bsum_q - BSW'(min_q) - BSW'(max_q);
				divisor  = DVW'(w_eff) - DVW'(2);
			end
			MODE_WEIGHTED: begin
				dividend = bsum_q;
				divisor  = DVW'(tri_prod >> 1);
			end
			MODE_BLOCK: begin
				dividend = bsum_q;
				divisor  = DVW'(w_eff);
			end
			default: begin
				dividend = bsum_q;
				divisor  = DVW'(w_eff);
			end
		endcase
	end

	logic [DVW:0] trial;
	logic         trial_ge;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign trial_ge = (trial >= {1'b0, dvs_q});

	assign status.div_last = (cnt_q == CNTW'(DW - 1));
	assign status.out_busy = out_valid_q && !out_ready;

	// ---- registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SLIDING;
			wlen_q      <= CFG_DATA_W'(1);
			sum_q       <= '0;
			bsum_q      <= '0;
			min_q       <= '0;
			max_q       <= '0;
			fill_q      <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_MODE:   mode_q <= mode_t'(cfg_wdata[1:0]);
					REG_WINDOW_LENGTH: wlen_q <= cfg_wdata;
					default: ;
				endcase
				sum_q  <= '0;
				bsum_q <= '0;
				min_q  <= '0;
				max_q  <= '0;
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (cmd.update) begin
				if (mode_q == MODE_SLIDING) begin
					sum_q  <= sum_upd;
					fill_q <= fill_slide;
					ptr_q  <= ptr_next;
					if (first_q) begin
						bsum_q <= '0;
						min_q  <= '0;
						max_q  <= '0;
					end
				end else if (trim_drop) begin
					sum_q  <= '0;
					bsum_q <= '0;
					min_q  <= '0;
					max_q  <= '0;
					fill_q <= '0;
					ptr_q  <= '0;
				end else begin
					bsum_q <= bsum_upd;
					min_q  <= min_upd;
					max_q  <= max_upd;
					fill_q <= fill_blk;
					if (first_q) begin
						sum_q <= '0;
						ptr_q <= '0;
					end
				end
			end else if (cmd.div_load && mode_q != MODE_SLIDING) begin
				// block consumed by the divider
				sum_q  <= '0;
				bsum_q <= '0;
				min_q  <= '0;
				max_q  <= '0;
				fill_q <= '0;
				ptr_q  <= '0;
			end

			if (cmd.div_load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNTW'(1);
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
			first_q  <= in_first;
		end
		if (cmd.div_load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DW-2:0], trial_ge};
			rem_q <= trial_ge ? DVW'(trial - {1'b0, dvs_q}) : DVW'(trial);
		end
		if (cmd.out_load) begin
			out_q <= quo_q[S-1:0];
		end
	end

	saf_ram #(
		.WIDTH(S),
		.DEPTH(MAX_WINDOW)
	) u_window (
		.clk  (clk),
		.we   (cmd.update && (mode_q == MODE_SLIDING)),
		.waddr(ptr_eff),
		.wdata(sample_q),
		.re   (cmd.capture),
		.raddr(ptr_q),
		.rdata(rd_data)
	);

	assign out_valid = out_valid_q;
	assign out_value = out_q;

	// ---- assertions ----
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= w_eff)
		else $error("fill count beyond window length");

	a_ptr_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(ptr_q) < w_eff)
		else $error("write pointer beyond window length");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> dvs_q != '0)
		else $error("division by zero");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("output register overwritten before its beat was taken");

	a_emit_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> $past(cmd.update) && $past(status.emit))
		else $error("divider started without a completed window");

endmodule

>>> verif/sample_averaging_filter_tb.sv
// sample_averaging_filter_tb: self-checking testbench for sample_averaging_filter.
// Needs saf_pkg and the filter RTL; directed table first, then random phases, each
// result checked against an in-bench model of the four modes or a pinned table value.
module sample_averaging_filter_tb
	import saf_pkg::*;
;

	localparam int SETTLE_CYCLES  = 40;    // covers a running divide plus no-result beats
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 360;

	typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		bit [CFG_INDEX_W-1:0]    idx;
		bit [CFG_DATA_W-1:0]     data;
		bit [15:0]               smp;
		bit                      first;
		bit                      pinned;
		bit [15:0]               pin_val;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [15:0]            s_tdata;   // sample
	logic                   s_tuser;   // first_of_record
	logic                   m_tvalid;
	logic                   m_tready;
	logic [15:0]            m_tdata;   // filtered_value

	// travels with each beat: expected value typed into the table
	logic                   beat_pinned;
	logic [15:0]            beat_pin_val;

	// filter model state
	mode_t                  cur_mode;
	bit [6:0]               win_len;
	bit [15:0]              win_store [SAF_MAX_WINDOW];
	bit [21:0]              run_sum;
	bit [27:0]              blk_sum;
	bit [15:0]              blk_min;
	bit [15:0]              blk_max;
	bit [6:0]               fill;
	bit [5:0]               wr_ptr;

	bit [15:0]              avg_expected_q [$];
	int                     mismatches;
	int                     quiet_cycles;
	bit                     calm;
	bit                     hold_req;
	row_t                   dir_rows [27];

	sample_averaging_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	function automatic void clear_state();
		run_sum = '0;
		blk_sum = '0;
		blk_min = '0;
		blk_max = '0;
		fill    = '0;
		wr_ptr  = '0;
	endfunction

	function automatic int eff_window();
		if (win_len == 0)
			return 1;
		if (win_len > SAF_MAX_WINDOW)
			return SAF_MAX_WINDOW;
		return int'(win_len);
	endfunction

	function automatic void apply_reg(input bit [CFG_INDEX_W-1:0] idx,
			input bit [CFG_DATA_W-1:0] data);
		if (idx == REG_FILTER_MODE)
			cur_mode = mode_t'(data[1:0]);
		else
			win_len = data;
		clear_state();
	endfunction

	// advances the model by one sample; returns 1 when a result is due
	function automatic bit average_step(input bit [15:0] smp, input bit first,
			output bit [15:0] avg);
		int        w;
		int        p;
		bit [31:0] quo;
		w   = eff_window();
		avg = '0;
		if (first)
			clear_state();
		if (cur_mode == MODE_SLIDING) begin
			p = int'(wr_ptr) % w;
			if (fill >= w)
				run_sum -= 22'(win_store[p]);
			else
				fill++;
			run_sum += 22'(smp);
			win_store[p] = smp;
			wr_ptr = 6'((p + 1) % w);
			if (fill < w)
				return 0;
			avg = 16'(run_sum / w);
			return 1;
		end
		if (fill >= w)
			fill = '0;
		if (fill == 0) begin
			blk_sum = '0;
			blk_min = smp;
			blk_max = smp;
		end else begin
			if (smp < blk_min)
				blk_min = smp;
			if (smp > blk_max)
				blk_max = smp;
		end
		if (cur_mode == MODE_WEIGHTED)
			blk_sum += 28'(smp * (fill + 1));
		else
			blk_sum += 28'(smp);
		fill++;
		if (fill < w)
			return 0;
		case (cur_mode)
			MODE_TRIMMED: begin
				if (w < TRIM_MIN_WINDOW) begin
					clear_state();
					return 0;
				end
				quo = (blk_sum - blk_min - blk_max) / (w - 2);
			end
			MODE_WEIGHTED: quo = blk_sum / (w * (w + 1) / 2);
			default:       quo = blk_sum / w;
		endcase
		clear_state();
		avg = quo[15:0];
		return 1;
	endfunction

	function automatic row_t plain_row(input bit [15:0] smp, input bit first);
		return '{ROW_BEAT, '0, '0, smp, first, 1'b0, 16'h0};
	endfunction

	function automatic row_t pinned_row(input bit [15:0] smp, input bit first,
			input bit [15:0] val);
		return '{ROW_BEAT, '0, '0, smp, first, 1'b1, val};
	endfunction

	function automatic row_t reg_row(input bit [CFG_INDEX_W-1:0] idx,
			input bit [CFG_DATA_W-1:0] data);
		return '{ROW_REG, idx, data, 16'h0, 1'b0, 1'b0, 16'h0};
	endfunction

	function automatic bit [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// model, checker and watchdog; all read pre-edge values
	always @(posedge clk) begin
		bit        due;
		bit [15:0] avg;
		bit [15:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (avg_expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = avg_expected_q.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: filtered_value expected %h, got %h", $time, want, m_tdata);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				apply_reg(cfg_index, cfg_wdata);
			if (s_tvalid && s_tready) begin
				due = average_step(s_tdata, s_tuser, avg);
				if (due)
					avg_expected_q.insert(avg_expected_q.size(),
						beat_pinned ? beat_pin_val : avg);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
				$display("sample_averaging_filter_tb: FAIL");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic put_beat(input bit [15:0] smp, input bit first, input bit pin,
			input bit [15:0] pin_val, input bit may_idle);
		if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid     <= 1'b1;
		s_tdata      <= smp;
		s_tuser      <= first;
		beat_pinned  <= pin;
		beat_pin_val <= pin_val;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending, let every expected result out, then let the block go idle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (avg_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_filter(input mode_t mode, input bit [6:0] wl);
		bit [CFG_DATA_W-1:0] mode_word;
		mode_word = {5'($urandom), mode};   // upper bits are don't-care
		if ($urandom_range(0, 1)) begin
			write_reg(REG_FILTER_MODE, mode_word);
			write_reg(REG_WINDOW_LENGTH, wl);
		end else begin
			write_reg(REG_WINDOW_LENGTH, wl);
			write_reg(REG_FILTER_MODE, mode_word);
		end
	endtask

	initial begin
		int       phase;
		int       n;
		int       rand_items;
		mode_t    mode;
		bit [6:0] wl;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		beat_pinned  = 1'b0;
		beat_pin_val = '0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		mismatches   = 0;
		quiet_cycles = 0;
		cur_mode     = MODE_SLIDING;
		win_len      = 7'd1;
		clear_state();

		dir_rows = '{
			pinned_row(16'h0000, 1'b1, 16'h0000),   // reset config: mode 0, window 1
			pinned_row(16'hFFFF, 1'b0, 16'hFFFF),
			reg_row(REG_WINDOW_LENGTH, 7'd0),        // zero window acts as 1
			pinned_row(16'h5555, 1'b0, 16'h5555),
			reg_row(REG_WINDOW_LENGTH, 7'd3),
			plain_row(16'hFFFF, 1'b0),
			plain_row(16'hFFFF, 1'b0),
			pinned_row(16'hFFFF, 1'b0, 16'hFFFF),
			plain_row(16'h0001, 1'b0),
			plain_row(16'h1234, 1'b1),               // new record inside a full window
			reg_row(REG_FILTER_MODE, {5'd0, MODE_TRIMMED}),
			plain_row(16'h0010, 1'b0),
			plain_row(16'h0100, 1'b0),
			pinned_row(16'h1000, 1'b0, 16'h0100),
			plain_row(16'hFFFF, 1'b0),
			plain_row(16'h0000, 1'b1),               // new record inside a block
			plain_row(16'h8000, 1'b0),
			plain_row(16'h7FFF, 1'b0),
			reg_row(REG_WINDOW_LENGTH, 7'd2),        // trimmed with W<3: no result
			plain_row(16'hFFFF, 1'b0),
			plain_row(16'h0000, 1'b0),
			reg_row(REG_FILTER_MODE, {5'd0, MODE_WEIGHTED}),
			plain_row(16'h0003, 1'b0),
			pinned_row(16'h0006, 1'b0, 16'h0005),
			reg_row(REG_FILTER_MODE, 7'h7F),         // block mean, upper data bits set
			plain_row(16'hFFFF, 1'b0),
			pinned_row(16'hFFFE, 1'b0, 16'hFFFE)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				put_beat(dir_rows[i].smp, dir_rows[i].first, dir_rows[i].pinned,
					dir_rows[i].pin_val, 1'b1);
		end

		rand_items = 0;
		phase      = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (phase == 2) begin
				// output backs up while beats keep coming
				mode = MODE_SLIDING;
				wl   = 7'd2;
			end else begin
				mode = mode_t'($urandom_range(0, 3));
				case ($urandom_range(0, 15))
					0:       wl = 7'd0;
					1:       wl = 7'd64;
					2:       wl = 7'($urandom_range(65, 127));
					3:       wl = 7'd2;
					4:       wl = 7'd3;
					default: wl = 7'($urandom_range(1, 10));
				endcase
			end
			program_filter(mode, wl);
			if (phase == 2) begin
				n = 40;
				hold_req = 1'b1;
			end else if (wl == 0 || wl > 10) begin
				n = $urandom_range(70, 140);
			end else begin
				n = $urandom_range(10, 40);
			end
			for (int i = 0; i < n; i++) begin
				if (phase == 4 && i == n / 2)
					settle();
				put_beat(rand_sample(), $urandom_range(0, 19) == 0, 1'b0, 16'h0, phase != 2);
				rand_items++;
			end
			phase++;
		end

		calm = 1'b1;
		program_filter(mode_t'($urandom_range(0, 3)), 7'($urandom_range(3, 6)));
		for (int i = 0; i < 40; i++)
			put_beat(rand_sample(), 1'b0, 1'b0, 16'h0, 1'b1);

		settle();
		if (mismatches == 0 && avg_expected_q.size() == 0)
			$display("sample_averaging_filter_tb: PASS");
		else
			$display("sample_averaging_filter_tb: FAIL");
		$finish;
	end

endmodule
